// ----- hw/rtl/lzx_pkg.sv -----
// Shared types and constants of the LZEXE stream decompressor.
// Used by the front parser, the command queue, the copy engine and the top level.
`timescale 1ns / 1ps

package lzx_pkg;

	localparam int WINDOW_SIZE      = 8192;
	localparam int HIST_AW          = $clog2(WINDOW_SIZE);
	localparam int BYTES_PER_RESULT = 4;
	// Results carry at most four byte fields.
	localparam int OUT_BYTES        = (BYTES_PER_RESULT > 4) ? 4 : BYTES_PER_RESULT;
	localparam int CNT_W            = $clog2(OUT_BYTES);
	localparam int COUNT_W          = 3;
	localparam int SPAN_W           = 16;
	localparam int LEN_W            = 9;

	typedef enum logic [1:0] {
		CMD_LIT  = 2'd0,
		CMD_COPY = 2'd1,
		CMD_END  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         lit;
		logic [SPAN_W-1:0]  span;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	typedef struct packed {
		logic [OUT_BYTES-1:0][7:0] data;
		logic [COUNT_W-1:0]        count;
		logic                      last;
		logic                      end_mark;
	} res_t;

endpackage

// ----- hw/rtl/lzx_front.sv -----
// Front parser: takes compressed stream bytes, tracks control bits and turns
// tokens into literal, copy and end commands. Depends on lzx_pkg.
`timescale 1ns / 1ps

module lzx_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    in_byte,
	input  logic          start_of_stream,
	output logic          full,
	output logic          cmd_push,
	output lzx_pkg::cmd_t cmd,
	input  logic          cmdq_full
);
	import lzx_pkg::*;

	typedef enum logic [8:0] {
		PH_BIT1      = 9'b000000001,
		PH_BIT2      = 9'b000000010,
		PH_LEN_HI    = 9'b000000100,
		PH_LEN_LO    = 9'b000001000,
		PH_LIT       = 9'b000010000,
		PH_SHORT_OFF = 9'b000100000,
		PH_LONG_OFF  = 9'b001000000,
		PH_LONG_LEN  = 9'b010000000,
		PH_EXT       = 9'b100000000
	} phase_t;

	localparam logic [4:0] WORD_BITS     = 5'd16;
	localparam logic [7:0] SHORT_SPAN_HI = 8'hFF;
	localparam logic [2:0] LONG_SPAN_TOP = 3'b111;

	phase_t      phase_q, phase_d;
	logic [15:0] ctrl_q, ctrl_d;
	logic [4:0]  bits_q, bits_d;
	logic        low_q, low_d;
	logic        ended_q, ended_d;
	logic [2:0]  len_q, len_d;
	logic [15:0] off_q, off_d;
	logic        bit_phase, busy, accept, cbit;

	assign bit_phase = (phase_q == PH_BIT1) || (phase_q == PH_BIT2) ||
	                   (phase_q == PH_LEN_HI) || (phase_q == PH_LEN_LO);
	// Control bits are spent one per cycle until a data byte is due.
	assign busy   = !ended_q && bit_phase && (bits_q != 5'd0);
	assign full   = busy || cmdq_full;
	assign accept = push && !full;
	assign cbit   = ctrl_q[0];

	always_comb begin
		ctrl_d   = ctrl_q;
		bits_d   = bits_q;
		low_d    = low_q;
		phase_d  = phase_q;
		len_d    = len_q;
		off_d    = off_q;
		ended_d  = ended_q;
		cmd_push = 1'b0;
		cmd      = '0;
		if (accept) begin
			if (start_of_stream) begin
				ctrl_d  = '0;
				bits_d  = '0;
				low_d   = 1'b0;
				phase_d = PH_BIT1;
				len_d   = '0;
				off_d   = '0;
				ended_d = 1'b0;
			end
			if (!ended_d) begin
				if (bits_d == 5'd0) begin
					if (!low_d) begin
						ctrl_d = {8'h00, in_byte};
						low_d  = 1'b1;
					end else begin
						ctrl_d = {in_byte, ctrl_d[7:0]};
						low_d  = 1'b0;
						bits_d = WORD_BITS;
					end
				end else begin
					case (phase_d)
						PH_LIT: begin
							cmd_push = 1'b1;
							cmd.kind = CMD_LIT;
							cmd.lit  = in_byte;
							phase_d  = PH_BIT1;
						end
						PH_SHORT_OFF: begin
							cmd_push = 1'b1;
							cmd.kind = CMD_COPY;
							cmd.span = {SHORT_SPAN_HI, in_byte};
							cmd.len  = LEN_W'(len_d);
							phase_d  = PH_BIT1;
						end
						PH_LONG_OFF: begin
							off_d   = {8'h00, in_byte};
							phase_d = PH_LONG_LEN;
						end
						PH_LONG_LEN: begin
							off_d = {LONG_SPAN_TOP, in_byte[7:3], off_d[7:0]};
							if (in_byte[2:0] == 3'd0) begin
								phase_d = PH_EXT;
							end else begin
								cmd_push = 1'b1;
								cmd.kind = CMD_COPY;
								cmd.span = off_d;
								cmd.len  = LEN_W'(in_byte[2:0]) + LEN_W'(2);
								phase_d  = PH_BIT1;
							end
						end
						PH_EXT: begin
							if (in_byte == 8'd0) begin
								cmd_push = 1'b1;
								cmd.kind = CMD_END;
								ended_d  = 1'b1;
							end else if (in_byte != 8'd1) begin
								cmd_push = 1'b1;
								cmd.kind = CMD_COPY;
								cmd.span = off_d;
								cmd.len  = LEN_W'(in_byte) + LEN_W'(1);
							end
							phase_d = PH_BIT1;
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end
			end
		end else if (busy) begin
			ctrl_d = {1'b0, ctrl_q[15:1]};
			bits_d = bits_q - 5'd1;
			case (phase_q)
				PH_BIT1:   phase_d = cbit ? PH_LIT : PH_BIT2;
				PH_BIT2:   phase_d = cbit ? PH_LONG_OFF : PH_LEN_HI;
				PH_LEN_HI: begin
					len_d   = {1'b0, cbit, 1'b0};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = (len_q | {2'b00, cbit}) + 3'd2;
					phase_d = PH_SHORT_OFF;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BIT1;
			ctrl_q  <= '0;
			bits_q  <= '0;
			low_q   <= 1'b0;
			ended_q <= 1'b0;
			len_q   <= '0;
			off_q   <= '0;
		end else begin
			phase_q <= phase_d;
			ctrl_q  <= ctrl_d;
			bits_q  <= bits_d;
			low_q   <= low_d;
			ended_q <= ended_d;
			len_q   <= len_d;
			off_q   <= off_d;
		end
	end

endmodule

// ----- hw/rtl/lzx_cmd_queue.sv -----
// Four-entry command queue between the front parser and the copy engine.
// Depends on lzx_pkg for the command type.
`timescale 1ns / 1ps

module lzx_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lzx_pkg::cmd_t din,
	output logic          full,
	input  logic          rd,
	output lzx_pkg::cmd_t dout,
	output logic          empty
);
	import lzx_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

endmodule

// ----- hw/rtl/lzx_back.sv -----
// Copy engine: carries out commands against the history window, packs output
// bytes into results and holds them in a two-entry result queue. Depends on lzx_pkg.
`timescale 1ns / 1ps

module lzx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  lzx_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output lzx_pkg::res_t res
);
	import lzx_pkg::*;

	logic [7:0]         hist_q [WINDOW_SIZE];
	logic [7:0]         rd_q;
	logic [HIST_AW-1:0] wp_q, src_q, wp_eff;
	logic               wrapped_q;
	logic               active_q;
	logic [LEN_W-1:0]   rem_q;

	logic               valid_s1, end_s1, last_s1, use_reg_s1;
	logic [7:0]         data_s1, byte_s1;

	logic [OUT_BYTES-1:0][7:0] acc_q;
	logic [CNT_W-1:0]          acc_cnt_q;

	res_t       rq_q [2];
	logic       rq_wptr_q, rq_rptr_q;
	logic [1:0] rq_cnt_q;
	logic       rq_full;

	logic take, adv, wr_en, issue, byp, written;
	logic res_push;
	res_t res_new;

	assign rq_full = (rq_cnt_q == 2'd2);
	assign empty   = (rq_cnt_q == 2'd0);
	assign res     = rq_q[rq_rptr_q];

	assign byte_s1 = use_reg_s1 ? data_s1 : rd_q;
	assign take    = valid_s1 && !rq_full;
	assign adv     = !valid_s1 || take;
	assign wr_en   = take && !end_s1;
	assign issue   = adv && active_q;
	assign cmd_pop = adv && !active_q && !cmd_empty;
	assign wp_eff  = wp_q + HIST_AW'(wr_en);

	// A read at the address written in the same cycle takes the new byte;
	// entries never written since reset read as zero.
	assign byp     = wr_en && (src_q == wp_q);
	assign written = wrapped_q || (src_q < wp_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_q[wp_q] <= byte_s1;
		end
		if (issue) begin
			rd_q <= hist_q[src_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			active_q  <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + HIST_AW'(1);
				if (wp_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
				active_q <= (rem_q != LEN_W'(1));
			end else if (cmd_pop) begin
				valid_s1 <= (cmd.kind != CMD_COPY);
				active_q <= (cmd.kind == CMD_COPY);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			src_q      <= src_q + HIST_AW'(1);
			rem_q      <= rem_q - LEN_W'(1);
			end_s1     <= 1'b0;
			last_s1    <= (rem_q == LEN_W'(1));
			use_reg_s1 <= byp || !written;
			data_s1    <= byp ? byte_s1 : 8'h00;
		end else if (cmd_pop) begin
			src_q      <= wp_eff + cmd.span[HIST_AW-1:0];
			rem_q      <= cmd.len;
			end_s1     <= (cmd.kind == CMD_END);
			last_s1    <= 1'b1;
			use_reg_s1 <= 1'b1;
			data_s1    <= cmd.lit;
		end
	end

	always_comb begin
		res_push = 1'b0;
		res_new  = '0;
		if (take) begin
			if (end_s1) begin
				res_push         = 1'b1;
				res_new.last     = 1'b1;
				res_new.end_mark = 1'b1;
			end else if ((acc_cnt_q == CNT_W'(OUT_BYTES-1)) || last_s1) begin
				res_push = 1'b1;
				for (int i = 0; i < OUT_BYTES; i++) begin
					if (CNT_W'(i) < acc_cnt_q) begin
						res_new.data[i] = acc_q[i];
					end else if (CNT_W'(i) == acc_cnt_q) begin
						res_new.data[i] = byte_s1;
					end
				end
				res_new.count = COUNT_W'(acc_cnt_q) + COUNT_W'(1);
				res_new.last  = last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !res_push) begin
			acc_q[acc_cnt_q] <= byte_s1;
		end
		if (res_push) begin
			rq_q[rq_wptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
			rq_wptr_q <= 1'b0;
			rq_rptr_q <= 1'b0;
			rq_cnt_q  <= '0;
		end else begin
			if (res_push) begin
				acc_cnt_q <= '0;
			end else if (wr_en) begin
				acc_cnt_q <= acc_cnt_q + CNT_W'(1);
			end
			if (res_push) begin
				rq_wptr_q <= !rq_wptr_q;
			end
			if (pop && !empty) begin
				rq_rptr_q <= !rq_rptr_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(pop && !empty);
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rq_full |=> valid_s1 && $stable(byte_s1) && $stable(last_s1) &&
		$stable(end_s1))
		else $error("stalled output word changed");

	a_no_pop_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !cmd_pop)
		else $error("command taken while a copy runs");

	a_end_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_new.end_mark |-> (acc_cnt_q == '0) && (res_new.count == '0))
		else $error("end mark with words still packed");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_new.last |=> (acc_cnt_q == '0))
		else $error("packer not empty after final result");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !rq_full)
		else $error("result queue overrun");

endmodule

// ----- hw/rtl/lzexe_stream_decompressor.sv -----
// LZEXE 0.91 stream decompressor, top level: front parser, command queue, copy engine.
// Depends on lzx_pkg, lzx_front, lzx_cmd_queue and lzx_back.
`timescale 1ns / 1ps

// Compressed bytes go in through push/full, one per accepted cycle, and results
// of up to four decoded bytes come out through empty/pop in stream order.
// Control bits are spent by the front sequencer at one per cycle, and no byte
// is taken while it does so. A match of L bytes runs in the copy engine at one
// history read per cycle while the result queue has room, and intake keeps
// going until the four-entry command queue fills. The 8K history needs no
// clearing pass: a fill mark on the write position makes entries not written
// since reset read as zero.
module lzexe_stream_decompressor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       start_of_stream,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte0,
	output logic [7:0] out_byte1,
	output logic [7:0] out_byte2,
	output logic [7:0] out_byte3,
	output logic [2:0] byte_count,
	output logic       last_of_run,
	output logic       end_mark
);
	import lzx_pkg::*;

	cmd_t cmd_in, cmd_out;
	res_t res;
	logic cmd_push, cmdq_full, cmd_pop, cmd_empty;

	lzx_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.in_byte         (in_byte),
		.start_of_stream (start_of_stream),
		.full            (full),
		.cmd_push        (cmd_push),
		.cmd             (cmd_in),
		.cmdq_full       (cmdq_full)
	);

	lzx_cmd_queue u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.din    (cmd_in),
		.full   (cmdq_full),
		.rd     (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	lzx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign out_byte0   = res.data[0];
	assign out_byte1   = res.data[1];
	assign out_byte2   = res.data[2];
	assign out_byte3   = res.data[3];
	assign byte_count  = res.count;
	assign last_of_run = res.last;
	assign end_mark    = res.end_mark;

endmodule
